// ===== hdl/irpdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpdt_pkg
// shared widths, register indexes and reset values of the ir transmitter
// ----------------------------------------------------------------------------
package irpdt_pkg;

  // fixed field widths
  localparam int unsigned TickW  = 16;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned BitsW  = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartTicks = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgOneTicks   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgZeroTicks  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgLowTicks   = 8'd3;

  // configuration reset values
  localparam logic [TickW-1:0] StartTicksRst = 16'd517;
  localparam logic [TickW-1:0] OneTicksRst   = 16'd255;
  localparam logic [TickW-1:0] ZeroTicksRst  = 16'd63;
  localparam logic [TickW-1:0] LowTicksRst   = 16'd64;

  // input word modes
  localparam logic ModeTick  = 1'b0;
  localparam logic ModeStart = 1'b1;

endpackage : irpdt_pkg
`default_nettype wire

// ===== hdl/ir_pulse_distance_transmitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_top
// pulse-distance infrared code transmitter, one result word per input word
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_ready_o) carries mode_i and code_word_i.
//   A start word (mode 1) loads the code and restarts the sequence; a tick
//   word (mode 0) advances the waveform by one carrier half-period.
//   Every accepted word yields one result word (ir_pin_o, busy_res_o) on the
//   output channel (out_valid_o / out_ready_i) in the cycle after acceptance.
//   Throughput is one word per cycle while the receiver does not stall: the
//   state update is a single pass of counter and compare logic, and the result
//   register is refilled in the same cycle in which its word is taken.
//   When the receiver stalls, the result register holds its word and
//   in_ready_o drops until it is taken; no word is lost.
//   The config channel (cfg_valid_i, cfg_index_i, cfg_data_i) is always
//   ready; indexes 0..3 select start, one, zero and low tick lengths,
//   other indexes are ignored.
//   Reset puts the lengths to their defaults, the pin level high and the block idle.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_top #(
  parameter int unsigned CODE_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [irpdt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [irpdt_pkg::TickW-1:0]      cfg_data_i,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              mode_i,
  input  wire  [irpdt_pkg::CodeW-1:0]      code_word_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             ir_pin_o,
  output logic                             busy_res_o
);

  localparam int unsigned ExtW = 16;

  // configuration registers
  logic [irpdt_pkg::TickW-1:0] start_ticks_q, one_ticks_q, zero_ticks_q, low_ticks_q;

  // sequencer state
  logic [CODE_BITS-1:0]        shift_code_q, shift_code_d;
  logic [irpdt_pkg::TickW-1:0] tick_count_q, tick_count_d;
  logic [irpdt_pkg::BitsW-1:0] bits_left_q, bits_left_d;
  logic active_q, active_d;
  logic in_start_q, in_start_d;
  logic bit_setup_q, bit_setup_d;
  logic first_half_q, first_half_d;
  logic pin_level_q, pin_level_d;

  // result register
  logic out_valid_q, ir_pin_q, busy_q;

  logic            in_accept;
  logic [ExtW-1:0] code_ext;
  logic            tick_zero;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign code_ext    = {{(ExtW - irpdt_pkg::CodeW){1'b0}}, code_word_i};
  assign tick_zero   = (tick_count_q == '0);

  assign out_valid_o = out_valid_q;
  assign ir_pin_o    = ir_pin_q;
  assign busy_res_o  = busy_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ticks_q <= irpdt_pkg::StartTicksRst;
      one_ticks_q   <= irpdt_pkg::OneTicksRst;
      zero_ticks_q  <= irpdt_pkg::ZeroTicksRst;
      low_ticks_q   <= irpdt_pkg::LowTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        irpdt_pkg::CfgStartTicks: start_ticks_q <= cfg_data_i;
        irpdt_pkg::CfgOneTicks:   one_ticks_q   <= cfg_data_i;
        irpdt_pkg::CfgZeroTicks:  zero_ticks_q  <= cfg_data_i;
        irpdt_pkg::CfgLowTicks:   low_ticks_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state for one accepted word
  always_comb begin
    shift_code_d = shift_code_q;
    tick_count_d = tick_count_q;
    bits_left_d  = bits_left_q;
    active_d     = active_q;
    in_start_d   = in_start_q;
    bit_setup_d  = bit_setup_q;
    first_half_d = first_half_q;
    pin_level_d  = pin_level_q;
    if (mode_i == irpdt_pkg::ModeStart) begin
      // load code and restart
      shift_code_d = code_ext[CODE_BITS-1:0];
      tick_count_d = start_ticks_q;
      bits_left_d  = irpdt_pkg::BitsW'(CODE_BITS);
      active_d     = 1'b1;
      in_start_d   = 1'b1;
      bit_setup_d  = 1'b0;
      first_half_d = 1'b0;
    end else if (active_q) begin
      if (in_start_q) begin
        // start burst
        pin_level_d = !pin_level_q;
        if (tick_zero) begin
          in_start_d  = 1'b0;
          bit_setup_d = 1'b1;
        end else begin
          tick_count_d = tick_count_q - irpdt_pkg::TickW'(1);
        end
      end else if (bit_setup_q) begin
        // setup tick, pick the next bit or finish
        bit_setup_d = 1'b0;
        if (bits_left_q == '0) begin
          pin_level_d = 1'b1;
          active_d    = 1'b0;
        end else begin
          bits_left_d  = bits_left_q - irpdt_pkg::BitsW'(1);
          tick_count_d = shift_code_q[CODE_BITS-1] ? one_ticks_q : zero_ticks_q;
          shift_code_d = shift_code_q << 1;
          first_half_d = 1'b1;
        end
      end else begin
        // high space, then toggling burst
        pin_level_d = first_half_q ? 1'b1 : !pin_level_q;
        if (tick_zero) begin
          if (first_half_q) begin
            first_half_d = 1'b0;
            tick_count_d = low_ticks_q;
          end else begin
            bit_setup_d = 1'b1;
          end
        end else begin
          tick_count_d = tick_count_q - irpdt_pkg::TickW'(1);
        end
      end
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_code_q <= '0;
      tick_count_q <= '0;
      bits_left_q  <= '0;
      active_q     <= 1'b0;
      in_start_q   <= 1'b0;
      bit_setup_q  <= 1'b0;
      first_half_q <= 1'b0;
      pin_level_q  <= 1'b1;
    end else if (in_accept) begin
      shift_code_q <= shift_code_d;
      tick_count_q <= tick_count_d;
      bits_left_q  <= bits_left_d;
      active_q     <= active_d;
      in_start_q   <= in_start_d;
      bit_setup_q  <= bit_setup_d;
      first_half_q <= first_half_d;
      pin_level_q  <= pin_level_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ir_pin_q <= pin_level_d;
      busy_q   <= active_d;
    end
  end

endmodule : ir_pulse_distance_transmitter_top
`default_nettype wire

// ===== test/ir_pulse_distance_transmitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_checker
// watches the config, input and output channels of the ir transmitter,
// predicts the pin level and busy flag of every accepted input word and
// compares each result word in order against the oldest prediction
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_checker
  import irpdt_pkg::*;
#(
  parameter int unsigned CODE_BITS = CodeW
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  input  wire                cfg_ready_i,
  input  wire  [CfgIdxW-1:0] cfg_index_i,
  input  wire  [TickW-1:0]   cfg_data_i,
  input  wire                in_valid_i,
  input  wire                in_ready_i,
  input  wire                mode_i,
  input  wire  [CodeW-1:0]   code_word_i,
  input  wire                out_valid_i,
  input  wire                out_ready_i,
  input  wire                ir_pin_i,
  input  wire                busy_res_i,
  output int                 err_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic pin;
    logic busy;
  } pin_word_t;

  // predicted result words, oldest first
  pin_word_t pin_words_q[$];

  // shadow of the tick length registers
  logic [TickW-1:0] len_start, len_one, len_zero, len_low;

  // shadow of the transmitter
  logic [CODE_BITS-1:0] code_sr;
  logic [TickW-1:0]     ticks_left;
  logic [BitsW-1:0]     bits_to_go;
  logic                 sending, in_lead, in_setup, in_space, pin_lvl;

  // advance the transmitter shadow by one word and return the expected result
  function automatic pin_word_t predict_word(logic m, logic [CodeW-1:0] c);
    pin_word_t w;
    if (m == ModeStart) begin
      code_sr    = c[CODE_BITS-1:0];
      ticks_left = len_start;
      bits_to_go = BitsW'(CODE_BITS);
      sending    = 1'b1;
      in_lead    = 1'b1;
      in_setup   = 1'b0;
      in_space   = 1'b0;
    end else if (sending) begin
      if (in_lead) begin
        // toggling start burst
        pin_lvl = ~pin_lvl;
        if (ticks_left == '0) begin
          in_lead  = 1'b0;
          in_setup = 1'b1;
        end else begin
          ticks_left = ticks_left - 1'b1;
        end
      end else if (in_setup) begin
        // setup tick: next bit loaded with the pin held, or sequence ends with the pin high
        in_setup = 1'b0;
        if (bits_to_go == '0) begin
          pin_lvl = 1'b1;
          sending = 1'b0;
        end else begin
          bits_to_go = bits_to_go - 1'b1;
          ticks_left = code_sr[CODE_BITS-1] ? len_one : len_zero;
          code_sr    = code_sr << 1;
          in_space   = 1'b1;
        end
      end else begin
        // high space, then toggling tail burst
        pin_lvl = in_space ? 1'b1 : ~pin_lvl;
        if (ticks_left == '0) begin
          if (in_space) begin
            in_space   = 1'b0;
            ticks_left = len_low;
          end else begin
            in_setup = 1'b1;
          end
        end else begin
          ticks_left = ticks_left - 1'b1;
        end
      end
    end
    w.pin  = pin_lvl;
    w.busy = sending;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pin_word_t exp_w;
    if (!rst_ni) begin
      len_start  = StartTicksRst;
      len_one    = OneTicksRst;
      len_zero   = ZeroTicksRst;
      len_low    = LowTicksRst;
      code_sr    = '0;
      ticks_left = '0;
      bits_to_go = '0;
      sending    = 1'b0;
      in_lead    = 1'b0;
      in_setup   = 1'b0;
      in_space   = 1'b0;
      pin_lvl    = 1'b1;
      pin_words_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // compare the result word taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (pin_words_q.size() == 0) begin
          err_count_o++;
          $display("%0t: result word with nothing expected, actual pin %0b busy %0b",
                   $time, ir_pin_i, busy_res_i);
        end else begin
          exp_w = pin_words_q.pop_front();
          if (ir_pin_i !== exp_w.pin) begin
            err_count_o++;
            $display("%0t: ir_pin mismatch, expected %0b, actual %0b",
                     $time, exp_w.pin, ir_pin_i);
          end
          if (busy_res_i !== exp_w.busy) begin
            err_count_o++;
            $display("%0t: busy_res mismatch, expected %0b, actual %0b",
                     $time, exp_w.busy, busy_res_i);
          end
        end
      end
      // register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgStartTicks: len_start = cfg_data_i;
          CfgOneTicks:   len_one   = cfg_data_i;
          CfgZeroTicks:  len_zero  = cfg_data_i;
          CfgLowTicks:   len_low   = cfg_data_i;
          default: ;
        endcase
      end
      // predict the word accepted at this edge
      if (in_valid_i && in_ready_i) begin
        pin_words_q.push_back(predict_word(mode_i, code_word_i));
      end
      pending_o = pin_words_q.size();
    end
  end

endmodule

// ===== test/tb_ir_pulse_distance_transmitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_transmitter_top
// drives start and tick words through the ir transmitter under several tick
// length settings and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_transmitter_top;
  import irpdt_pkg::*;

  localparam int unsigned CodeBits = CodeW;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = ModeTick;
  logic [CodeW-1:0]   code_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ir_pin;
  logic               busy_res;
  int                 err_count;
  int                 pending;

  // idle pattern of the current phase, in percent
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // tick lengths last written, used to shape whole sequences
  int cur_start = StartTicksRst;
  int cur_one   = OneTicksRst;
  int cur_zero  = ZeroTicksRst;
  int cur_low   = LowTicksRst;

  ir_pulse_distance_transmitter_top #(
    .CODE_BITS (CodeBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .code_word_i (code_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .ir_pin_o    (ir_pin),
    .busy_res_o  (busy_res)
  );

  ir_pulse_distance_transmitter_checker #(
    .CODE_BITS (CodeBits)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .mode_i      (mode),
    .code_word_i (code_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .ir_pin_i    (ir_pin),
    .busy_res_i  (busy_res),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // one input word, with random sender gaps in front
  task automatic send_word(input logic m, input logic [CodeW-1:0] c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    code_word <= c;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // one register write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= TickW'(data);
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgStartTicks: cur_start = data;
      CfgOneTicks:   cur_one   = data;
      CfgZeroTicks:  cur_zero  = data;
      CfgLowTicks:   cur_low   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_lengths(input int s, input int o, input int z, input int l);
    cfg_write(CfgStartTicks, s);
    cfg_write(CfgOneTicks, o);
    cfg_write(CfgZeroTicks, z);
    cfg_write(CfgLowTicks, l);
    // a write to an unused index must be dropped
    cfg_write(CfgIdxW'($urandom_range(CfgLowTicks + 1, (1 << CfgIdxW) - 1)), $urandom);
  endtask

  // stop sending and let every expected result word arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // tick words needed to send a whole code with the current lengths
  function automatic int code_ticks(input logic [CodeW-1:0] c);
    int total;
    total = cur_start + 1 + 1;
    for (int i = 0; i < CodeBits; i++) begin
      total += 1 + (c[CodeBits-1-i] ? cur_one : cur_zero) + 1 + cur_low + 1;
    end
    return total;
  endfunction

  // mostly whole codes with random content, some cut short, some noise
  task automatic run_traffic(input int n_items);
    int sent;
    int seq_len;
    logic [CodeW-1:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        c = CodeW'($urandom);
        send_word(ModeStart, c);
        sent++;
        seq_len = code_ticks(c) + $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 15) seq_len = $urandom_range(0, seq_len);
        for (int k = 0; k < seq_len && sent < n_items; k++) begin
          send_word(ModeTick, CodeW'($urandom));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_word(($urandom_range(0, 7) == 0) ? ModeStart : ModeTick, CodeW'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle ticks, start, restart while sending, extreme codes
    send_word(ModeTick, 12'hFFF);
    send_word(ModeTick, 12'h000);
    send_word(ModeStart, 12'hFFF);
    repeat (5) send_word(ModeTick, 12'h000);
    send_word(ModeStart, 12'h000);
    repeat (4) send_word(ModeTick, 12'hFFF);
    send_word(ModeStart, 12'hA5A);
    repeat (3) send_word(ModeTick, 12'h5A5);
    wait_drained();

    // shortest lengths, written while a code is still going out
    load_lengths(0, 0, 0, 0);
    run_traffic(450);
    wait_drained();

    // small lengths, sender gaps, one full pause in the middle
    sender_idle_pct = 50;
    load_lengths($urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(0, 3), $urandom_range(0, 3));
    run_traffic(200);
    wait_drained();
    run_traffic(200);
    wait_drained();

    // medium lengths, receiver stalls
    sender_idle_pct = 0;
    recv_stall_pct  = 50;
    load_lengths($urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15));
    run_traffic(400);
    wait_drained();

    // longest lengths: start burst, then space and tail
    sender_idle_pct = 10;
    recv_stall_pct  = 10;
    load_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(60);
    wait_drained();
    load_lengths(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(90);
    wait_drained();

    // mixed lengths
    load_lengths($urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 31));
    run_traffic(450);
    wait_drained();

    // back to the power-up lengths
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    load_lengths(StartTicksRst, OneTicksRst, ZeroTicksRst, LowTicksRst);
    run_traffic(100);
    wait_drained();

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/irpdt_pkg.sv
hdl/ir_pulse_distance_transmitter_top.sv
test/ir_pulse_distance_transmitter_checker.sv
test/tb_ir_pulse_distance_transmitter_top.sv
